// ----- sv/lswa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswa_pkg
// Shared constants, types and arithmetic helpers of the scan window average.
// ----------------------------------------------------------------------------
package lswa_pkg;

  localparam int MAX_BEAMS     = 1024;
  localparam int WINDOW        = 8;
  localparam int CORDIC_STAGES = 16;

  localparam int BEAM_W     = $clog2(MAX_BEAMS);
  localparam int BCNT_W     = BEAM_W + 1;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int FILL_W     = $clog2(WINDOW + 1);
  localparam int HIST_DEPTH = WINDOW * MAX_BEAMS;
  localparam int HIST_AW    = SLOT_W + BEAM_W;

  localparam int INDEX_W    = 10;
  localparam int COORD_W    = 17;
  localparam int RANGE_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = COORD_W + SLOT_W;
  localparam int HIST_W     = 2 * COORD_W;
  localparam int BSUM_W     = 2 * SUM_W + WINDOW;

  localparam int ANG_W  = 24;
  localparam int CW     = 36;
  localparam int PROD_W = 46;

  localparam logic [29:0]           GAIN_Q30    = 30'd652032874;
  localparam logic signed [CW-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 24'sd12868;

  typedef enum logic [1:0] {
    CFG_ANGLE_START = 2'd0,
    CFG_ANGLE_STEP  = 2'd1,
    CFG_HALF_FIELD  = 2'd2,
    CFG_MIN_RANGE   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              skip;
    logic [BEAM_W-1:0] beam;
    logic [SLOT_W-1:0] slot;
    logic              drop_old;
    logic              win_chk;
    logic              eos;
    logic              ok;
  } item_ctl_t;

  typedef struct packed {
    logic [INDEX_W-1:0]        beam_index;
    logic signed [COORD_W-1:0] avg_x;
    logic signed [COORD_W-1:0] avg_y;
    logic                      point_valid;
    logic                      scan_done;
  } result_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 36'sd843314857;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043837;
      3:  a = 36'sd133525159;
      4:  a = 36'sd67021687;
      5:  a = 36'sd33543516;
      6:  a = 36'sd16775851;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194283;
      9:  a = 36'sd2097149;
      10: a = 36'sd1048575;
      11: a = 36'sd524288;
      12: a = 36'sd262144;
      13: a = 36'sd131072;
      14: a = 36'sd65536;
      15: a = 36'sd32768;
      16: a = 36'sd16384;
      17: a = 36'sd8192;
      18: a = 36'sd4096;
      19: a = 36'sd2048;
      20: a = 36'sd1024;
      21: a = 36'sd512;
      22: a = 36'sd256;
      23: a = 36'sd128;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [COORD_W-1:0] round_sat(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    logic signed [COORD_W-1:0] q;
    t = (CW+1)'(v) + (CW+1)'(32768);
    r = t >>> 16;
    if (r > (CW+1)'(65535)) begin
      q = 17'sd65535;
    end else if (r < -(CW+1)'(65535)) begin
      q = -17'sd65535;
    end else begin
      q = COORD_W'(r);
    end
    return q;
  endfunction

endpackage

// ----- sv/lswa_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswa_sample_if
// Range sample channel: one beam per request.
// ----------------------------------------------------------------------------
interface lswa_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        end_of_scan;

  modport source (output valid, range_mm, end_of_scan, input ready);
  modport sink   (input valid, range_mm, end_of_scan, output ready);
endinterface

// ----- sv/lswa_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswa_result_if
// Averaged point channel: one result per request.
// ----------------------------------------------------------------------------
interface lswa_result_if;
  logic               valid;
  logic               ready;
  logic [9:0]         beam_index;
  logic signed [16:0] avg_x;
  logic signed [16:0] avg_y;
  logic               point_valid;
  logic               scan_done;

  modport source (output valid, beam_index, avg_x, avg_y, point_valid, scan_done,
                  input ready);
  modport sink   (input valid, beam_index, avg_x, avg_y, point_valid, scan_done,
                  output ready);
endinterface

// ----- sv/lswa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswa_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lswa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/lidar_scan_window_average_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_window_average_core
// Lidar samples to cartesian points, averaged per beam over recent scans.
// ----------------------------------------------------------------------------
// Usage: range samples enter on the sample channel one beam at a time, the
// last beam of a scan flagged by end_of_scan. Each sample gives one result on
// the result channel: beam index, window averaged x and y and a valid flag.
// Configuration writes go through cfg_we / cfg_index / cfg_data while idle;
// the user must keep to this, the core itself does not enforce it.
// Stages: angle, gain multiply, 16 CORDIC stages, rounding, memory
// read-modify-write and output buffer, in that order.
// Throughput: one sample per cycle when not stalled; the beam sum memory is
// read and written once per sample, with forwarding between neighbor samples.
// Reset: configuration returns to defaults and a clearing pass over every
// beam address zeroes the beam sum memory; sample.ready stays low during it.
// Stall: a two entry output buffer holds results; the pipeline freezes only
// when the buffer is full and the receiver is not ready.
// ----------------------------------------------------------------------------
module lidar_scan_window_average_core (
  input  logic                        clk,
  input  logic                        rst,
  lswa_sample_if.sink                 sample,
  lswa_result_if.source               result,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [lswa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lswa_pkg::*;

  logic signed [15:0] angle_start;
  logic [11:0]        angle_step;
  logic [14:0]        half_field;
  logic [15:0]        min_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= -16'sd25736;
      angle_step  <= 12'd36;
      half_field  <= 15'd12861;
      min_range   <= 16'd2000;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ANGLE_START: angle_start <= $signed(cfg_data[15:0]);
        CFG_ANGLE_STEP:  angle_step  <= cfg_data[11:0];
        CFG_HALF_FIELD:  half_field  <= cfg_data[14:0];
        CFG_MIN_RANGE:   min_range   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output buffer
  result_t    q [2];
  logic       q_wr, q_rd;
  logic [1:0] q_cnt;
  logic       en, push, pop;
  result_t    m_res;

  assign en  = (q_cnt != 2'd2) || result.ready;
  assign pop = (q_cnt != 2'd0) && result.ready;

  // clearing pass
  logic              clr_busy;
  logic [BEAM_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BEAM_W'(MAX_BEAMS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  logic accept;
  assign sample.ready = en && !clr_busy;
  assign accept       = sample.valid && sample.ready;

  // scan position
  logic [BCNT_W-1:0] beam_counter;
  logic [SLOT_W-1:0] slot_pointer;
  logic [FILL_W-1:0] scans_filled;
  logic              in_map;

  assign in_map = beam_counter < BCNT_W'(MAX_BEAMS);

  always_ff @(posedge clk) begin
    if (rst) begin
      beam_counter <= '0;
      slot_pointer <= '0;
      scans_filled <= '0;
    end else if (accept) begin
      if (sample.end_of_scan) begin
        beam_counter <= '0;
        slot_pointer <= (slot_pointer == SLOT_W'(WINDOW - 1)) ? '0 : slot_pointer + 1'b1;
        if (scans_filled < FILL_W'(WINDOW)) begin
          scans_filled <= scans_filled + 1'b1;
        end
      end else if (in_map) begin
        beam_counter <= beam_counter + 1'b1;
      end
    end
  end

  // stage 0: beam angle
  logic [21:0]             ang_prod;
  logic                    s0_v;
  item_ctl_t               s0_ctl;
  logic [RANGE_W-1:0]      s0_range;
  logic signed [ANG_W-1:0] s0_ang;
  logic [INDEX_W-1:0]      s0_index;

  assign ang_prod = 22'(angle_step) * 22'(beam_counter[BEAM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl.skip     <= !in_map;
      s0_ctl.beam     <= beam_counter[BEAM_W-1:0];
      s0_ctl.slot     <= slot_pointer;
      s0_ctl.drop_old <= scans_filled >= FILL_W'(WINDOW);
      s0_ctl.win_chk  <= (scans_filled + 1'b1) >= FILL_W'(WINDOW);
      s0_ctl.eos      <= sample.end_of_scan;
      s0_ctl.ok       <= 1'b0;
      s0_range        <= sample.range_mm;
      s0_ang          <= ANG_W'(angle_start) + $signed(ANG_W'(ang_prod));
      s0_index        <= INDEX_W'(beam_counter);
    end
  end

  // stage 1: limits, pre-rotation, gain
  logic signed [ANG_W-1:0] hf;
  logic                    s1_ok, s1_flip;
  logic signed [CW-1:0]    z_base, z_init;
  logic [PROD_W-1:0]       gain_prod;
  item_ctl_t               c0_ctl_next;

  assign hf        = $signed(ANG_W'(half_field));
  assign s1_ok     = (s0_ang >= -hf) && (s0_ang <= hf) && (s0_range >= min_range);
  assign s1_flip   = (s0_ang > HALF_PI_Q13) || (s0_ang < -HALF_PI_Q13);
  assign z_base    = {{2{s0_ang[16]}}, s0_ang[16:0], 17'b0};
  assign z_init    = !s1_flip ? z_base : (s0_ang > 0) ? z_base - PI_Q30 : z_base + PI_Q30;
  assign gain_prod = PROD_W'(s0_range) * PROD_W'(GAIN_Q30);

  always_comb begin
    c0_ctl_next    = s0_ctl;
    c0_ctl_next.ok = s1_ok && !s0_ctl.skip;
  end

  logic                 c_v    [CORDIC_STAGES+1];
  item_ctl_t            c_ctl  [CORDIC_STAGES+1];
  logic                 c_flip [CORDIC_STAGES+1];
  logic [INDEX_W-1:0]   c_idx  [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_x    [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_y    [CORDIC_STAGES+1];
  logic signed [CW-1:0] c_z    [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v[0] <= 1'b0;
    end else if (en) begin
      c_v[0] <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_ctl[0]    <= c0_ctl_next;
      c_flip[0]   <= s1_flip;
      c_idx[0]    <= s0_index;
      c_x[0]      <= CW'({1'b0, gain_prod[PROD_W-1:14]});
      c_y[0]      <= '0;
      c_z[0]      <= z_init;
    end
  end

  // CORDIC rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [CW-1:0] dx, dy;
    assign dx = c_x[i] >>> i;
    assign dy = c_y[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        c_v[i+1] <= 1'b0;
      end else if (en) begin
        c_v[i+1] <= c_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_ctl[i+1]  <= c_ctl[i];
        c_flip[i+1] <= c_flip[i];
        c_idx[i+1]  <= c_idx[i];
        if (!c_z[i][CW-1]) begin
          c_x[i+1] <= c_x[i] - dy;
          c_y[i+1] <= c_y[i] + dx;
          c_z[i+1] <= c_z[i] - atan_q30(i);
        end else begin
          c_x[i+1] <= c_x[i] + dy;
          c_y[i+1] <= c_y[i] - dx;
          c_z[i+1] <= c_z[i] + atan_q30(i);
        end
      end
    end
  end

  // rounding stage
  logic signed [CW-1:0]      fx, fy;
  logic signed [COORD_W-1:0] rx, ry;
  logic                      r_ok_n;
  item_ctl_t                 r_ctl_next;

  assign fx     = c_flip[CORDIC_STAGES] ? -c_x[CORDIC_STAGES] : c_x[CORDIC_STAGES];
  assign fy     = c_flip[CORDIC_STAGES] ? -c_y[CORDIC_STAGES] : c_y[CORDIC_STAGES];
  assign rx     = round_sat(fx);
  assign ry     = round_sat(fy);
  assign r_ok_n = c_ctl[CORDIC_STAGES].ok && (rx != '0) && (ry != '0);

  always_comb begin
    r_ctl_next    = c_ctl[CORDIC_STAGES];
    r_ctl_next.ok = r_ok_n;
  end

  logic                      r_v;
  item_ctl_t                 r_ctl;
  logic [INDEX_W-1:0]        r_idx;
  logic signed [COORD_W-1:0] r_x, r_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= c_v[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_ctl    <= r_ctl_next;
      r_idx    <= c_idx[CORDIC_STAGES];
      r_x      <= r_ok_n ? rx : '0;
      r_y      <= r_ok_n ? ry : '0;
    end
  end

  // memory stage
  logic                      m_v;
  item_ctl_t                 m_ctl;
  logic [INDEX_W-1:0]        m_idx;
  logic signed [COORD_W-1:0] m_x, m_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ctl <= r_ctl;
      m_idx <= r_idx;
      m_x   <= r_x;
      m_y   <= r_y;
    end
  end

  logic [BSUM_W-1:0]  bsum_rdata, bsum_wdata, bsum_cur, bsum_new;
  logic [BEAM_W-1:0]  bsum_waddr;
  logic               bsum_we;
  logic [HIST_W-1:0]  hist_rdata;
  logic               m_wr;

  logic              fw_v;
  logic [BEAM_W-1:0] fw_addr;
  logic [BSUM_W-1:0] fw_data;

  logic signed [SUM_W-1:0]   sx, sy, nsx, nsy;
  logic [WINDOW-1:0]         mask, nmask;
  logic signed [COORD_W-1:0] ox, oy;

  assign m_wr     = en && m_v && !m_ctl.skip;
  assign bsum_cur = (fw_v && fw_addr == m_ctl.beam) ? fw_data : bsum_rdata;
  assign sx       = $signed(bsum_cur[BSUM_W-1 -: SUM_W]);
  assign sy       = $signed(bsum_cur[WINDOW +: SUM_W]);
  assign mask     = bsum_cur[WINDOW-1:0];
  assign ox       = $signed(hist_rdata[HIST_W-1 -: COORD_W]);
  assign oy       = $signed(hist_rdata[COORD_W-1:0]);

  always_comb begin
    nsx = sx + SUM_W'(m_x);
    nsy = sy + SUM_W'(m_y);
    if (m_ctl.drop_old) begin
      nsx = nsx - SUM_W'(ox);
      nsy = nsy - SUM_W'(oy);
    end
    nmask             = mask;
    nmask[m_ctl.slot] = m_ctl.ok;
  end

  assign bsum_new   = {nsx, nsy, nmask};
  assign bsum_we    = clr_busy || m_wr;
  assign bsum_waddr = clr_busy ? clr_addr : m_ctl.beam;
  assign bsum_wdata = clr_busy ? '0 : bsum_new;

  always_ff @(posedge clk) begin
    if (rst || clr_busy) begin
      fw_v <= 1'b0;
    end else if (m_wr) begin
      fw_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_wr) begin
      fw_addr <= m_ctl.beam;
      fw_data <= bsum_new;
    end
  end

  lswa_ram #(.WIDTH(BSUM_W), .DEPTH(MAX_BEAMS)) u_bsum_ram (
    .clk   (clk),
    .we    (bsum_we),
    .waddr (bsum_waddr),
    .wdata (bsum_wdata),
    .re    (en),
    .raddr (r_ctl.beam),
    .rdata (bsum_rdata)
  );

  lswa_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (m_wr),
    .waddr ({m_ctl.slot, m_ctl.beam}),
    .wdata ({m_x, m_y}),
    .re    (en),
    .raddr ({r_ctl.slot, r_ctl.beam}),
    .rdata (hist_rdata)
  );

  logic pv;
  assign pv = !m_ctl.skip && m_ctl.win_chk && (&nmask);

  always_comb begin
    m_res.beam_index  = m_idx;
    m_res.avg_x       = pv ? COORD_W'(nsx >>> SLOT_W) : '0;
    m_res.avg_y       = pv ? COORD_W'(nsy >>> SLOT_W) : '0;
    m_res.point_valid = pv;
    m_res.scan_done   = m_ctl.eos;
  end

  assign push = en && m_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= 1'b0;
      q_rd  <= 1'b0;
      q_cnt <= '0;
    end else begin
      if (push) begin
        q_wr <= !q_wr;
      end
      if (pop) begin
        q_rd <= !q_rd;
      end
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[q_wr] <= m_res;
    end
  end

  assign result.valid       = q_cnt != 2'd0;
  assign result.beam_index  = q[q_rd].beam_index;
  assign result.avg_x       = q[q_rd].avg_x;
  assign result.avg_y       = q[q_rd].avg_y;
  assign result.point_valid = q[q_rd].point_valid;
  assign result.scan_done   = q[q_rd].scan_done;

endmodule

// ----- sv/lswa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lswa_checker
// Port level checks of the scan window average core.
// ----------------------------------------------------------------------------
module lswa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [16:0] avg_x,
  input logic signed [16:0] avg_y,
  input logic        point_valid
);
  // clearing pass blocks requests right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("sample ready right after reset");

  // an invalid point carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !point_valid |-> avg_x == 17'sd0 && avg_y == 17'sd0)
    else $error("invalid point with nonzero coordinates");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");
endmodule

bind lidar_scan_window_average_core lswa_checker u_lswa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .avg_x       (result.avg_x),
  .avg_y       (result.avg_y),
  .point_valid (result.point_valid)
);
